// ----- rtl/tspr_pkg.sv -----
package tspr_pkg;

    localparam int unsigned FirePulseLen = 100;
    localparam int unsigned TargetNum = 30000000;
    localparam int unsigned OnThreshold = 10;

    localparam int ErrW = 27;
    localparam int YW = 48;
    localparam int CoefW = 18;
    localparam int ProdW = ErrW + CoefW;
    localparam int AccW = YW + 3;
    localparam int QW = 25;
    localparam int DivW = 25;
    localparam int AddrW = 5;

    typedef enum logic [1:0] {
        OP_HALL    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_ZERO    = 2'd3
    } op_t;

    localparam logic [2:0] REG_KP      = 3'd0;
    localparam logic [2:0] REG_KI      = 3'd1;
    localparam logic [2:0] REG_KD      = 3'd2;
    localparam logic [2:0] REG_DMAX    = 3'd3;
    localparam logic [2:0] REG_DMIN    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_HALFW   = 3'd6;
    localparam logic [2:0] REG_OFFSET  = 3'd7;

    typedef enum logic [1:0] {
        MSEL_E0 = 2'd0,
        MSEL_E1 = 2'd1,
        MSEL_E2 = 2'd2
    } msel_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       mul_step;
        msel_t      msel;
        logic       finish;
    } tspr_cmd_t;

    typedef struct packed {
        logic div_last;
    } tspr_sts_t;

endpackage

// ----- rtl/tspr_datapath.sv -----
module tspr_datapath
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tspr_cmd_t   cmd,
    output tspr_sts_t   sts,
    input  logic [1:0]  op,
    input  logic [15:0] hall_period,
    input  logic [11:0] speed_setpoint,
    input  logic        setpoint_valid,
    input  logic        half_wave_positive,
    input  logic [15:0] gain_prop,
    input  logic [15:0] gain_integ,
    input  logic [15:0] gain_deriv,
    input  logic [15:0] drive_max,
    input  logic [15:0] drive_min,
    input  logic [15:0] hall_timeout,
    input  logic [15:0] half_wave_len,
    input  logic [15:0] second_wave_offset,
    output logic        fire,
    output logic [15:0] compare_value,
    output logic [15:0] reload_value,
    output logic        motor_enabled,
    output logic [15:0] drive_level
);

    logic [1:0]             op_reg;
    logic                   pos_reg;
    logic [11:0]            sp_reg;
    logic [12:0]            divisor_reg;
    logic [QW-1:0]          quo_reg;
    logic [12:0]            rem_reg;
    logic [AddrW-1:0]       cnt_reg;
    logic signed [AccW-1:0] acc_reg;
    logic [15:0]            period_reg;
    logic signed [ErrW-1:0] err1_reg;
    logic signed [ErrW-1:0] err2_reg;
    logic signed [YW-1:0]   yprev_reg;
    logic [15:0]            drive_reg;
    logic                   on_reg;

    localparam logic [DivW-1:0] Num = DivW'(TargetNum);

    logic [13:0]            rem_sh;
    logic [13:0]            rem_sub;
    logic signed [ErrW-1:0] err_cur;
    logic signed [17:0]     kp;
    logic signed [17:0]     ki;
    logic signed [17:0]     kd;
    logic signed [CoefW-1:0] coef;
    logic signed [ErrW-1:0] mop;
    logic signed [ProdW-1:0] prod;
    logic signed [AccW-1:0] ysat;
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    logic [15:0]            base;

    assign rem_sh  = {rem_reg, Num[AddrW'(DivW - 1) - cnt_reg]};
    assign rem_sub = rem_sh - {1'b0, divisor_reg};
    assign err_cur = $signed({11'd0, period_reg}) - $signed({2'b00, quo_reg});

    assign kp = 18'(signed'(gain_prop));
    assign ki = 18'(signed'(gain_integ));
    assign kd = 18'(signed'(gain_deriv));

    always_comb begin
        unique case (cmd.msel)
            MSEL_E0: begin coef = kp + ki + kd; mop = err_cur;  end
            MSEL_E1: begin coef = -kp - (kd <<< 1); mop = err1_reg; end
            default: begin coef = kd; mop = err2_reg; end
        endcase
    end
    assign prod = ProdW'(coef) * ProdW'(mop);

    localparam logic signed [AccW-1:0] YMax = AccW'({1'b0, {(YW-1){1'b1}}});
    localparam logic signed [AccW-1:0] YMin = -YMax - AccW'(1);

    always_comb begin
        priority if (acc_reg > YMax) ysat = YMax;
        else if (acc_reg < YMin) ysat = YMin;
        else ysat = acc_reg;
    end
    assign hi = $signed({27'd0, drive_max, 8'd0});
    assign lo = $signed({27'd0, drive_min, 8'd0});
    assign base = half_wave_len - drive_reg;
    assign sts.div_last = (cnt_reg == AddrW'(DivW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            err1_reg   <= '0;
            err2_reg   <= '0;
            yprev_reg  <= '0;
            drive_reg  <= '0;
            on_reg     <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cmd.load) begin
                op_reg      <= op;
                pos_reg     <= half_wave_positive;
                sp_reg      <= setpoint_valid ? speed_setpoint : 12'd0;
                divisor_reg <= (setpoint_valid ? {1'b0, speed_setpoint} : 13'd0) + 13'd1;
                rem_reg     <= '0;
                quo_reg     <= '0;
                cnt_reg     <= '0;
                if (op == OP_HALL) period_reg <= hall_period;
                if (op == OP_TIMEOUT) period_reg <= hall_timeout;
            end
            if (cmd.div_step) begin
                cnt_reg <= cnt_reg + AddrW'(1);
                if (!rem_sub[13]) begin
                    rem_reg <= rem_sub[12:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[12:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                acc_reg <= AccW'(yprev_reg);
            end
            if (cmd.mul_step) acc_reg <= acc_reg + AccW'(prod);
            if (cmd.finish) begin
                on_reg   <= (sp_reg > 12'(OnThreshold)) && !err_cur[ErrW-1];
                err2_reg <= err1_reg;
                err1_reg <= err_cur;
                priority if (ysat > hi) begin
                    drive_reg <= drive_max;
                    yprev_reg <= YW'(hi);
                end else if (ysat < lo) begin
                    drive_reg <= drive_min;
                    yprev_reg <= YW'(lo);
                end else begin
                    drive_reg <= ysat[23:8];
                    yprev_reg <= YW'(ysat);
                end
            end
        end
    end

    always_comb begin
        fire = 1'b0;
        compare_value = '0;
        reload_value = '0;
        if (op_reg == OP_ZERO && on_reg) begin
            fire = 1'b1;
            if (pos_reg) begin
                compare_value = base - 16'(FirePulseLen);
                reload_value  = base;
            end else begin
                compare_value = base - second_wave_offset - 16'(FirePulseLen);
                reload_value  = half_wave_len - drive_min - second_wave_offset;
            end
        end
    end
    assign motor_enabled = on_reg;
    assign drive_level   = drive_reg;

endmodule

// ----- rtl/tspr_ctrl.sv -----
module tspr_ctrl
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    input  tspr_sts_t   sts,
    output tspr_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_M0, ST_M1, ST_M2, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        cmd = '0;
        cmd.load = s_valid && s_ready;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul_step = (state_reg == ST_M0) || (state_reg == ST_M1) || (state_reg == ST_M2);
        unique case (state_reg)
            ST_M1:   cmd.msel = MSEL_E1;
            ST_M2:   cmd.msel = MSEL_E2;
            default: cmd.msel = MSEL_E0;
        endcase
        cmd.finish = (state_reg == ST_FIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_valid) state_reg <= (s_operation == OP_UPDATE) ? ST_DIV : ST_OUT;
                ST_DIV:  if (sts.div_last) state_reg <= ST_M0;
                ST_M0:   state_reg <= ST_M1;
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_FIN;
                ST_FIN:  state_reg <= ST_OUT;
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/triac_speed_pid_regulator.sv -----
// channel | handshake          | payload
// s_      | s_valid / s_ready  | operation, hall_period, speed_setpoint, setpoint_valid,
//         |                    | half_wave_positive
// m_      | m_valid / m_ready  | fire, compare_value, reload_value, motor_enabled, drive_level
// Hall, timeout and zero-cross words go straight from acceptance to the output register;
// an update runs acceptance, the restoring divider (one quotient bit a cycle), the
// shared multiplier, the clamp and then the output register.
// Reset restores register defaults and clears state.
// A word waits in the output register until m_ready; no input is taken meanwhile.
module triac_speed_pid_regulator
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_hall_period,
    input  logic [11:0] s_speed_setpoint,
    input  logic        s_setpoint_valid,
    input  logic        s_half_wave_positive,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fire,
    output logic [15:0] m_compare_value,
    output logic [15:0] m_reload_value,
    output logic        m_motor_enabled,
    output logic [15:0] m_drive_level
);

    logic [15:0] regs_reg [8];
    tspr_cmd_t   cmd;
    tspr_sts_t   sts;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign prdata = {16'd0, regs_reg[ridx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_KP]      <= 16'd179;
            regs_reg[REG_KI]      <= 16'd0;
            regs_reg[REG_KD]      <= 16'd0;
            regs_reg[REG_DMAX]    <= 16'd5000;
            regs_reg[REG_DMIN]    <= 16'd0;
            regs_reg[REG_TIMEOUT] <= 16'd60000;
            regs_reg[REG_HALFW]   <= 16'd10000;
            regs_reg[REG_OFFSET]  <= 16'd0;
        end else if (psel && penable && pwrite) begin
            regs_reg[ridx] <= pwdata[15:0];
        end
    end

    tspr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    tspr_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .op(s_operation), .hall_period(s_hall_period),
        .speed_setpoint(s_speed_setpoint), .setpoint_valid(s_setpoint_valid),
        .half_wave_positive(s_half_wave_positive),
        .gain_prop(regs_reg[REG_KP]), .gain_integ(regs_reg[REG_KI]),
        .gain_deriv(regs_reg[REG_KD]), .drive_max(regs_reg[REG_DMAX]),
        .drive_min(regs_reg[REG_DMIN]), .hall_timeout(regs_reg[REG_TIMEOUT]),
        .half_wave_len(regs_reg[REG_HALFW]), .second_wave_offset(regs_reg[REG_OFFSET]),
        .fire(m_fire), .compare_value(m_compare_value), .reload_value(m_reload_value),
        .motor_enabled(m_motor_enabled), .drive_level(m_drive_level)
    );

endmodule

// ----- rtl/tspr_checker.sv -----
module tspr_props (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_fire,
    input logic m_motor_enabled,
    input logic [15:0] m_drive_level
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while word pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_level))
        else $error("pending word changed");

    a_fire_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fire |-> m_motor_enabled) else $error("fire with motor off");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

endmodule

bind triac_speed_pid_regulator tspr_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_fire(m_fire),
    .m_motor_enabled(m_motor_enabled), .m_drive_level(m_drive_level)
);

// ----- sim/tspr_checker.sv -----
`timescale 1ns / 100ps

module tspr_checker
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_hall_period,
    input  logic [11:0] s_speed_setpoint,
    input  logic        s_setpoint_valid,
    input  logic        s_half_wave_positive,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_fire,
    input  logic [15:0] m_compare_value,
    input  logic [15:0] m_reload_value,
    input  logic        m_motor_enabled,
    input  logic [15:0] m_drive_level,
    output int          fail_count,
    output int          pending_words
);

    typedef struct packed {
        logic        fire;
        logic [15:0] cmp;
        logic [15:0] rld;
        logic        on;
        logic [15:0] drive;
    } firing_t;

    localparam longint YMax = 64'sd140737488355327;
    localparam longint YMin = -YMax - 1;

    logic [15:0] regs [8];
    logic [15:0] period_q;
    longint      err_q1, err_q2, y_q;
    logic [15:0] drive_q;
    logic        on_q;
    firing_t     expected_words [$];

    function automatic longint sx16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    task automatic regulate(input logic [1:0] op_bits, input logic [15:0] hp,
                            input logic [11:0] sp_in, input logic spv, input logic pos);
        op_t     op;
        firing_t w;
        longint  kp, ki, kd, e, y, hi, lo, sp;
        op = op_t'(op_bits);
        w = '0;
        case (op)
            OP_HALL: period_q = hp;
            OP_TIMEOUT: period_q = regs[REG_TIMEOUT];
            OP_UPDATE: begin
                sp = spv ? longint'(sp_in) : 0;
                kp = sx16(regs[REG_KP]);
                ki = sx16(regs[REG_KI]);
                kd = sx16(regs[REG_KD]);
                e = longint'(period_q) - 30000000 / (sp + 1);
                on_q = (sp > 10) && (e >= 0);
                y = (kp + ki + kd) * e + (-kp - 2 * kd) * err_q1 + kd * err_q2 + y_q;
                if (y > YMax) y = YMax;
                else if (y < YMin) y = YMin;
                err_q2 = err_q1;
                err_q1 = e;
                hi = longint'(regs[REG_DMAX]) * 256;
                lo = longint'(regs[REG_DMIN]) * 256;
                if (y > hi) begin
                    drive_q = regs[REG_DMAX];
                    y_q = hi;
                end else if (y < lo) begin
                    drive_q = regs[REG_DMIN];
                    y_q = lo;
                end else begin
                    drive_q = 16'(y >>> 8);
                    y_q = y;
                end
            end
            OP_ZERO: if (on_q) begin
                w.fire = 1'b1;
                if (pos) begin
                    w.cmp = regs[REG_HALFW] - drive_q - 16'(FirePulseLen);
                    w.rld = regs[REG_HALFW] - drive_q;
                end else begin
                    w.cmp = regs[REG_HALFW] - drive_q - regs[REG_OFFSET] - 16'(FirePulseLen);
                    w.rld = regs[REG_HALFW] - regs[REG_DMIN] - regs[REG_OFFSET];
                end
            end
        endcase
        w.on = on_q;
        w.drive = drive_q;
        expected_words.push_back(w);
    endtask

    task automatic compare(input string nm, input logic [15:0] exp_v, input logic [15:0] act);
        if (exp_v !== act) begin
            $error("%s expected %0h actual %0h", nm, exp_v, act);
            fail_count++;
        end
    endtask

    assign pending_words = expected_words.size();

    always @(posedge aclk) begin
        firing_t w;
        if (!aresetn) begin
            regs[REG_KP] <= 16'd179;
            regs[REG_KI] <= 16'd0;
            regs[REG_KD] <= 16'd0;
            regs[REG_DMAX] <= 16'd5000;
            regs[REG_DMIN] <= 16'd0;
            regs[REG_TIMEOUT] <= 16'd60000;
            regs[REG_HALFW] <= 16'd10000;
            regs[REG_OFFSET] <= 16'd0;
            period_q = '0;
            err_q1 = 0;
            err_q2 = 0;
            y_q = 0;
            drive_q = '0;
            on_q = 1'b0;
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready)
                regs[paddr[4:2]] <= pwdata[15:0];
            if (s_valid && s_ready)
                regulate(s_operation, s_hall_period, s_speed_setpoint,
                         s_setpoint_valid, s_half_wave_positive);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("word with no expectation");
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    compare("fire", 16'(w.fire), 16'(m_fire));
                    compare("compare_value", w.cmp, m_compare_value);
                    compare("reload_value", w.rld, m_reload_value);
                    compare("motor_enabled", 16'(w.on), 16'(m_motor_enabled));
                    compare("drive_level", w.drive, m_drive_level);
                end
            end
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import tspr_pkg::*;

    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_ready;
    logic [1:0]  s_operation = '0;
    logic [15:0] s_hall_period = '0;
    logic [11:0] s_speed_setpoint = '0;
    logic        s_setpoint_valid = 1'b0, s_half_wave_positive = 1'b0;
    logic        m_valid, m_ready = 1'b0;
    logic        m_fire, m_motor_enabled;
    logic [15:0] m_compare_value, m_reload_value, m_drive_level;
    int          fail_count, pending_words;
    int          idle_cycles = 0;
    logic [3:0]  stall_pattern;

    always #5 aclk = ~aclk;

    triac_speed_pid_regulator uut (.*);

    tspr_checker checker_i (.*);

    // receiver stalls by a rotating pattern that changes now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_pattern <= 4'b1011;
            m_ready <= 1'b0;
        end else begin
            stall_pattern <= ($urandom_range(0, 63) == 0) ? 4'($urandom)
                             : {stall_pattern[2:0], stall_pattern[3]};
            m_ready <= stall_pattern[0] | ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(input op_t op, input logic [15:0] hp, input logic [11:0] sp,
                             input logic spv, input logic pos);
        s_valid <= 1'b1;
        s_operation <= op;
        s_hall_period <= hp;
        s_speed_setpoint <= sp;
        s_setpoint_valid <= spv;
        s_half_wave_positive <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_word(input int mode);
        int          r;
        logic [15:0] hp;
        r = $urandom_range(0, 9);
        hp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 30000));
        if (mode == 1 && r < 7)
            // sane words: a period, an update or a zero cross, picked at random
            case (r % 4)
                0: send_word(OP_HALL, hp, '0, 1'b0, 1'b0);
                1: send_word(OP_UPDATE, '0, 12'($urandom_range(11, 4095)), 1'b1, 1'b0);
                default: send_word(OP_ZERO, '0, '0, 1'b0, 1'($urandom));
            endcase
        else
            send_word(op_t'($urandom), 16'($urandom), 12'($urandom), 1'($urandom),
                      1'($urandom));
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6)) go_idle();
    endtask

    initial begin
        logic [15:0] settings [8];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, extremes, each op, setpoint invalid and at threshold
        send_word(OP_HALL, 16'hFFFF, '0, 1'b0, 1'b0);
        send_word(OP_UPDATE, '0, 12'd11, 1'b1, 1'b0);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b1);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b0);
        send_word(OP_UPDATE, '0, 12'd10, 1'b1, 1'b1);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b1);
        send_word(OP_HALL, 16'h0000, 12'hFFF, 1'b1, 1'b1);
        send_word(OP_UPDATE, '0, 12'hFFF, 1'b1, 1'b0);
        send_word(OP_UPDATE, '0, 12'hFFF, 1'b0, 1'b0);
        send_word(OP_TIMEOUT, '0, '0, 1'b0, 1'b0);
        send_word(OP_UPDATE, '0, 12'hFFF, 1'b1, 1'b0);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b0);
        drain();

        // extreme gains, min above max, offsets
        write_reg(REG_KP, 16'h7FFF);
        write_reg(REG_KI, 16'h8000);
        write_reg(REG_KD, 16'h7FFF);
        write_reg(REG_DMAX, 16'd100);
        write_reg(REG_DMIN, 16'd200);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_HALFW, 16'd0);
        write_reg(REG_OFFSET, 16'hFFFF);
        send_word(OP_TIMEOUT, '0, '0, 1'b0, 1'b0);
        send_word(OP_UPDATE, '0, 12'hFFF, 1'b1, 1'b0);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b1);
        send_word(OP_ZERO, '0, '0, 1'b0, 1'b0);
        send_word(OP_HALL, 16'd1, '0, 1'b0, 1'b0);
        send_word(OP_UPDATE, '0, 12'hFFF, 1'b1, 1'b0);
        send_word(OP_UPDATE, '0, 12'd0, 1'b1, 1'b0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                for (int i = 0; i < 8; i++)
                    settings[i] = 16'($urandom);
                if (phase == 1) begin
                    settings[REG_KP] = 16'h8000;
                    settings[REG_KI] = 16'h7FFF;
                    settings[REG_KD] = 16'h8000;
                    settings[REG_DMAX] = 16'hFFFF;
                    settings[REG_DMIN] = 16'd0;
                    settings[REG_TIMEOUT] = 16'd1;
                end else if (phase > 2) begin
                    settings[REG_KP] = 16'($urandom_range(0, 2000));
                    settings[REG_KI] = 16'($signed(16'($urandom_range(0, 200))) - 16'sd100);
                    settings[REG_KD] = 16'($urandom_range(0, 200));
                    settings[REG_DMAX] = 16'($urandom_range(3000, 9000));
                    settings[REG_DMIN] = 16'($urandom_range(0, 2000));
                    settings[REG_HALFW] = 16'($urandom_range(8000, 10000));
                end
                for (int i = 0; i < 8; i++)
                    write_reg(3'(i), settings[i]);
            end
            for (int n = 0; n < 210; n++) begin
                if (n == 100) drain();
                random_word((n % 50) < 40 ? 1 : 0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tspr_pkg.sv
rtl/tspr_datapath.sv
rtl/tspr_ctrl.sv
rtl/triac_speed_pid_regulator.sv
rtl/tspr_checker.sv
sim/tspr_checker.sv
sim/testbench.sv
